// File: design/tile_background_window_pixel_defines.svh
// Assertion macros shared by the checker of the background and window pixel unit
`ifndef TILE_BACKGROUND_WINDOW_PIXEL_DEFINES_SVH
`define TILE_BACKGROUND_WINDOW_PIXEL_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset
`define TBWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbwp: next-cycle check failed");

// Same check, but also evaluated while reset is asserted
`define TBWP_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tbwp: next-cycle check failed across reset");

`endif

// File: design/tbwp_pkg.sv
// Types and constants of the background and window pixel unit
package tbwp_pkg;

  // Request operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_CTRL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_OFS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_OFS_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_PALETTE  = 3'd5;

  localparam logic [7:0] PALETTE_RESET = 8'hFC;

  // Display control bit positions
  localparam int unsigned CTL_BG_EN    = 0;
  localparam int unsigned CTL_BG_MAP   = 3;
  localparam int unsigned CTL_TILE_SEL = 4;
  localparam int unsigned CTL_WIN_EN   = 5;
  localparam int unsigned CTL_WIN_MAP  = 6;

  // Video memory layout: two byte banks of 4096 words (even and odd bytes)
  localparam int unsigned VRAM_AW  = 13;
  localparam int unsigned VRAM_WAW = VRAM_AW - 1;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE    = 13'h1C00;
  localparam logic [VRAM_AW-1:0] MAP_LOW_BASE     = 13'h1800;
  localparam logic [VRAM_AW-1:0] SIGNED_TILE_BASE = 13'h1000;

  localparam logic [7:0] SCREEN_WIDTH = 8'd160;

  typedef struct packed {
    logic       operation;
    logic [12:0] address;
    logic [7:0] data;
    logic [7:0] line;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] color_number;
    logic       from_window;
  } out_item_t;

  typedef struct packed {
    logic [7:0] disp_ctrl;
    logic [7:0] bg_ofs_y;
    logic [7:0] bg_ofs_x;
    logic [7:0] win_top;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
  } cfg_regs_t;

  // Write request to the video memory banks
  typedef struct packed {
    logic                en;
    logic [1:0]          lane_en;
    logic [VRAM_WAW-1:0] idx;
    logic [7:0]          data;
  } vram_wr_t;

endpackage

// File: design/tbwp_cfg.sv
// Configuration register file of the background and window pixel unit
module tbwp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output tbwp_pkg::cfg_regs_t            regs
);

  tbwp_pkg::cfg_regs_t regs_r;
  tbwp_pkg::cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        tbwp_pkg::REG_DISP_CTRL:  regs_nxt.disp_ctrl   = cfg_data;
        tbwp_pkg::REG_BG_OFS_Y:   regs_nxt.bg_ofs_y    = cfg_data;
        tbwp_pkg::REG_BG_OFS_X:   regs_nxt.bg_ofs_x    = cfg_data;
        tbwp_pkg::REG_WIN_TOP:    regs_nxt.win_top     = cfg_data;
        tbwp_pkg::REG_WINDOW_X:   regs_nxt.window_x    = cfg_data;
        tbwp_pkg::REG_BG_PALETTE: regs_nxt.bg_palette  = cfg_data;
        default:                  regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.disp_ctrl   <= 8'h00;
      regs_r.bg_ofs_y    <= 8'h00;
      regs_r.bg_ofs_x    <= 8'h00;
      regs_r.win_top     <= 8'h00;
      regs_r.window_x    <= 8'h00;
      regs_r.bg_palette  <= tbwp_pkg::PALETTE_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: design/tbwp_vram.sv
// Video memory: even and odd byte banks with one write and one registered read port
module tbwp_vram (
  input  logic                              clk,
  input  tbwp_pkg::vram_wr_t                wr,
  input  logic                              rd_en,
  input  logic [tbwp_pkg::VRAM_WAW-1:0]     rd_idx,
  output logic [7:0]                        rd_lo,
  output logic [7:0]                        rd_hi
);

  localparam int unsigned WORDS = 1 << tbwp_pkg::VRAM_WAW;

  logic [7:0] even_mem [0:WORDS-1];
  logic [7:0] odd_mem  [0:WORDS-1];
  logic [7:0] rd_lo_r;
  logic [7:0] rd_hi_r;

  // Write the selected byte lanes
  always_ff @(posedge clk) begin
    if (wr.en && wr.lane_en[0]) begin
      even_mem[wr.idx] <= wr.data;
    end
    if (wr.en && wr.lane_en[1]) begin
      odd_mem[wr.idx] <= wr.data;
    end
  end

  // Read both lanes of one word, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= even_mem[rd_idx];
      rd_hi_r <= odd_mem[rd_idx];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule

// File: design/tile_background_window_pixel.sv
// Top level of the background and window pixel unit
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries write and render requests.
//   A write request stores one byte in the 8 KiB video memory and gives no result.
//   A render request with column below 160 gives one result on the output channel
//   (out_valid / out_stall / out_data); one with a larger column gives none.
//   Configuration registers are written over cfg_valid / cfg_ready / cfg_index /
//   cfg_data; cfg_ready is always high and unknown indexes are ignored.
// Render sequence:
//   A render request reads the tile map on acceptance, then the two bitplane bytes
//   of the tile row from the same memory, and the result is then loaded into the
//   output register. The single read port blocks a new render while the tile row is
//   fetched; write requests are taken every cycle while no render is in progress.
// Reset:
//   rst_n is synchronous, active low. After reset a clearing pass zeroes the video
//   memory, one word a cycle over all 4096 words, with in_stall held high throughout.
// Back-pressure:
//   A result waits in the output register while out_stall is high; the next render
//   may be fetched meanwhile and then waits until the output register frees.
module tile_background_window_pixel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tbwp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tbwp_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int unsigned WAW = tbwp_pkg::VRAM_WAW;
  localparam int unsigned AW  = tbwp_pkg::VRAM_AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_TILE  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  tbwp_pkg::cfg_regs_t regs;
  tbwp_pkg::vram_wr_t  wr;

  logic [1:0]     state_r, state_nxt;
  logic [WAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  tbwp_pkg::out_item_t out_data_r;

  // Per-render context carried from map read to pixel select
  logic       win_r;
  logic       blank_r;
  logic       byte_sel_r;
  logic [2:0] fine_y_r;
  logic [2:0] fine_x_r;

  logic           load_ok;
  logic           accept_ok;
  logic           in_acc;
  logic           wr_acc;
  logic           render_acc;
  logic           rd_en;
  logic [WAW-1:0] rd_idx;
  logic [7:0]     rd_lo;
  logic [7:0]     rd_hi;

  logic [8:0]    col_p7;
  logic          win_hit;
  logic          bg_on;
  logic [7:0]    ty;
  logic [7:0]    tx;
  logic [AW-1:0] map_base;
  logic [AW-1:0] map_addr;
  logic [7:0]    tile_num;
  logic [AW-1:0] tile_base;
  logic [AW-1:0] data_addr;
  logic [2:0]    bit_idx;
  logic [1:0]    color;
  logic [1:0]    shade;

  tbwp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tbwp_vram u_vram (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_lo  (rd_lo),
    .rd_hi  (rd_hi)
  );

  // Handshake: accept in idle, or when the finished pixel can leave this cycle
  assign load_ok    = !out_valid_r || !out_stall;
  assign accept_ok  = (state_r == ST_IDLE) || ((state_r == ST_DONE) && load_ok);
  assign in_stall   = !accept_ok;
  assign in_acc     = in_valid && accept_ok;
  assign wr_acc     = in_acc && (in_data.operation == tbwp_pkg::OP_WRITE);
  assign render_acc = in_acc && (in_data.operation == tbwp_pkg::OP_RENDER) &&
                      (in_data.column < tbwp_pkg::SCREEN_WIDTH);

  // Layer select and map address for the request on the input
  always_comb begin
    col_p7  = {1'b0, in_data.column} + 9'd7;
    win_hit = regs.disp_ctrl[tbwp_pkg::CTL_WIN_EN] &&
              (in_data.line >= regs.win_top) && (col_p7 >= {1'b0, regs.window_x});
    bg_on   = regs.disp_ctrl[tbwp_pkg::CTL_BG_EN];
    if (win_hit) begin
      ty       = in_data.line - regs.win_top;
      tx       = 8'(col_p7 - {1'b0, regs.window_x});
      map_base = regs.disp_ctrl[tbwp_pkg::CTL_WIN_MAP] ? tbwp_pkg::MAP_HIGH_BASE
                                                      : tbwp_pkg::MAP_LOW_BASE;
    end else begin
      ty       = in_data.line + regs.bg_ofs_y;
      tx       = in_data.column + regs.bg_ofs_x;
      map_base = regs.disp_ctrl[tbwp_pkg::CTL_BG_MAP] ? tbwp_pkg::MAP_HIGH_BASE
                                                     : tbwp_pkg::MAP_LOW_BASE;
    end
    map_addr = map_base + {3'b000, ty[7:3], tx[7:3]};
  end

  // Tile data address from the fetched tile number
  always_comb begin
    tile_num = byte_sel_r ? rd_hi : rd_lo;
    if (regs.disp_ctrl[tbwp_pkg::CTL_TILE_SEL]) begin
      tile_base = {1'b0, tile_num, 4'b0000};
    end else begin
      tile_base = tbwp_pkg::SIGNED_TILE_BASE + {tile_num[7], tile_num, 4'b0000};
    end
    data_addr = tile_base + {9'd0, fine_y_r, 1'b0};
  end

  // Read port: map word on acceptance, tile row word in the fetch state
  assign rd_en  = render_acc || (state_r == ST_TILE);
  assign rd_idx = (state_r == ST_TILE) ? data_addr[AW-1:1] : map_addr[AW-1:1];

  // Write port: clearing pass, else accepted byte writes
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr.en      = 1'b1;
      wr.lane_en = 2'b11;
      wr.idx     = clr_cnt_r;
      wr.data    = 8'h00;
    end else begin
      wr.en      = wr_acc;
      wr.lane_en = {in_data.address[0], ~in_data.address[0]};
      wr.idx     = in_data.address[AW-1:1];
      wr.data    = in_data.data;
    end
  end

  // Pixel select and palette
  always_comb begin
    bit_idx = ~fine_x_r;
    color   = {rd_hi[bit_idx], rd_lo[bit_idx]};
    shade   = regs.bg_palette[{color, 1'b0} +: 2];
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (render_acc) begin
          state_nxt = ST_TILE;
        end
      end
      ST_TILE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_ok) begin
          state_nxt = render_acc ? ST_TILE : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid: hold while stalled, set when a pixel finishes
  assign out_valid_nxt = (out_valid_r && out_stall) || ((state_r == ST_DONE) && load_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the render context on acceptance
  always_ff @(posedge clk) begin
    if (render_acc) begin
      win_r      <= win_hit;
      blank_r    <= !win_hit && !bg_on;
      byte_sel_r <= map_addr[0];
      fine_y_r   <= ty[2:0];
      fine_x_r   <= tx[2:0];
    end
  end

  // Load the finished pixel
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && load_ok) begin
      if (blank_r) begin
        out_data_r.shade        <= 2'd0;
        out_data_r.color_number <= 2'd0;
        out_data_r.from_window  <= 1'b0;
      end else begin
        out_data_r.shade        <= shade;
        out_data_r.color_number <= color;
        out_data_r.from_window  <= win_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/tbwp_checker.sv
// Port checker of the background and window pixel unit, bound to the top level
`include "tile_background_window_pixel_defines.svh"

module tbwp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tbwp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tbwp_pkg::out_item_t out_data
);

  logic render_acc;

  assign render_acc = in_valid && !in_stall &&
                      (in_data.operation == tbwp_pkg::OP_RENDER) &&
                      (in_data.column < tbwp_pkg::SCREEN_WIDTH);

  // A stalled result stays offered and unchanged
  `TBWP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `TBWP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  // The memory clearing pass blocks requests right after reset
  `TBWP_ASSERT_NEXT_ANY(a_clear_stall, !rst_n, in_stall)
  // A render occupies the read port for its tile fetch in the next cycle
  `TBWP_ASSERT_NEXT(a_render_gap, render_acc, in_stall)

endmodule

bind tile_background_window_pixel tbwp_checker u_tbwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
